// ===== design/dnalu_pkg.sv =====
`timescale 1ns / 1ps

package dnalu_pkg;

  // Fraction bits of the signed fixed-point format.
  localparam int FRAC_BITS = 16;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int WIDE_W = PROD_W + 2;
  // Scaled dividend: a product magnitude shifted up by the fraction bits.
  localparam int NUM_W = PROD_W + FRAC_BITS;
  // Quotient bits kept; anything at or above bit QUO_W is flagged as too big.
  localparam int QUO_W = DATA_W + 1;
  localparam int NUM_STEPS = QUO_W;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_CONJ  = 3'd2,
    OP_MUL   = 3'd3,
    OP_SCALE = 3'd4,
    OP_DIV   = 3'd5
  } op_t;

  // One quotient lane of the restoring divider.
  typedef struct packed {
    logic              neg;
    logic              big;
    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  q;
  } lane_t;

  typedef struct packed {
    logic              is_div;
    logic [DATA_W-1:0] res_real;
    logic [DATA_W-1:0] res_dual;
    logic              sat;
    logic              dbz;
    logic [PROD_W-1:0] den;
    lane_t             lr;
    lane_t             ld;
  } pipe_t;

  // Clip a wide signed value to the 32-bit range; the top bit flags a clip.
  function automatic logic [DATA_W:0] clip_wide(input logic signed [WIDE_W-1:0] w);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed({{(WIDE_W-DATA_W){1'b0}}, SAT_MAX});
    lo = $signed({{(WIDE_W-DATA_W){1'b1}}, SAT_MIN});
    if (w > hi) begin
      clip_wide = {1'b1, SAT_MAX};
    end else if (w < lo) begin
      clip_wide = {1'b1, SAT_MIN};
    end else begin
      clip_wide = {1'b0, w[DATA_W-1:0]};
    end
  endfunction

  // Turn a finished quotient lane into a signed, saturated result.
  function automatic logic [DATA_W:0] lane_result(input lane_t l);
    logic [DATA_W-1:0] neg_q;
    neg_q = ~l.q[DATA_W-1:0] + DATA_W'(1);
    if (!l.neg) begin
      if (l.big || l.q[QUO_W-1:QUO_W-2] != 2'b00) begin
        lane_result = {1'b1, SAT_MAX};
      end else begin
        lane_result = {1'b0, l.q[DATA_W-1:0]};
      end
    end else begin
      if (l.big || l.q > {2'b01, {(QUO_W-2){1'b0}}}) begin
        lane_result = {1'b1, SAT_MIN};
      end else begin
        lane_result = {1'b0, neg_q};
      end
    end
  endfunction

  // One restoring division step: bring down one dividend bit.
  function automatic lane_t lane_step(input lane_t l, input logic [PROD_W-1:0] den,
                                      input int idx);
    lane_t             o;
    logic [PROD_W:0]   t;
    logic [PROD_W:0]   d;
    o = l;
    t = {l.rem, l.num[idx]};
    d = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      o.rem = d[PROD_W-1:0];
      o.q   = {l.q[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = t[PROD_W-1:0];
      o.q   = {l.q[QUO_W-2:0], 1'b0};
    end
    lane_step = o;
  endfunction

endpackage

// ===== design/dual_number_alu_core.sv =====
`timescale 1ns / 1ps
// Pipeline: two arithmetic stages, one divider setup stage, 33 restoring divide
// steps and the output register; the divide steps are one pipeline stage each.
// Throughput: one beat per cycle while out_ready does not stall the output.
// Stalls only back up the pipeline as far as the first empty stage.
// Reset (rst, synchronous) clears every valid bit; data registers are not reset.
module dual_number_alu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_dual,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_dual,
  input  logic signed [31:0] factor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] res_real,
  output logic signed [31:0] res_dual,
  output logic        saturated,
  output logic        divide_by_zero
);

  localparam int NS  = dnalu_pkg::NUM_STEPS;
  localparam int PW  = dnalu_pkg::PROD_W;
  localparam int WW  = dnalu_pkg::WIDE_W;
  localparam int FB  = dnalu_pkg::FRAC_BITS;
  localparam int QW  = dnalu_pkg::QUO_W;
  localparam int NW  = dnalu_pkg::NUM_W;

  // Stage 1: products and short sums.
  logic                   v1;
  dnalu_pkg::op_t         op1;
  logic                   bz1;
  logic signed [PW-1:0]   m0, m1, m2;
  logic [PW-1:0]          m3;
  logic signed [32:0]     sum_r, sum_d;

  // Stage 2: wide results and divider magnitudes.
  logic                   v2;
  dnalu_pkg::op_t         op2;
  logic                   bz2;
  logic signed [WW-1:0]   rr_w, rd_w;
  logic [PW-1:0]          den2;
  logic                   neg_r2, neg_d2;
  logic [PW-1:0]          mag_r2, mag_d2;

  // Stage 3 onward: divider setup and one stage per quotient bit.
  logic                   vp [0:NS];
  dnalu_pkg::pipe_t       pipe [0:NS];
  dnalu_pkg::pipe_t       pipe_step [1:NS];
  dnalu_pkg::pipe_t       p0_next;

  logic                   e1, e2, eo;
  logic                   ep [0:NS];

  // Stage enables: a stage loads when it is empty or its content moves on.
  always_comb begin
    eo = !out_valid || out_ready;
    ep[NS] = !vp[NS] || eo;
    for (int k = NS - 1; k >= 0; k--) begin
      ep[k] = !vp[k] || ep[k+1];
    end
    e2 = !v2 || ep[0];
    e1 = !v1 || e2;
  end

  assign in_ready = e1;

  // Stage 1 inputs.
  dnalu_pkg::op_t        op_in;
  logic signed [31:0]    mul_b;
  logic signed [32:0]    sum_r_next, sum_d_next;

  always_comb begin
    op_in = dnalu_pkg::op_t'(opcode);
    mul_b = (op_in == dnalu_pkg::OP_SCALE) ? factor : b_real;
    sum_r_next = '0;
    sum_d_next = '0;
    case (op_in)
      dnalu_pkg::OP_ADD: begin
        sum_r_next = $signed({a_real[31], a_real}) + $signed({b_real[31], b_real});
        sum_d_next = $signed({a_dual[31], a_dual}) + $signed({b_dual[31], b_dual});
      end
      dnalu_pkg::OP_SUB: begin
        sum_r_next = $signed({a_real[31], a_real}) - $signed({b_real[31], b_real});
        sum_d_next = $signed({a_dual[31], a_dual}) - $signed({b_dual[31], b_dual});
      end
      dnalu_pkg::OP_CONJ: begin
        sum_r_next = $signed({a_real[31], a_real});
        sum_d_next = -$signed({a_dual[31], a_dual});
      end
      default: begin
        sum_r_next = '0;
        sum_d_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      op1   <= op_in;
      bz1   <= (b_real == 32'sd0);
      m0    <= a_real * mul_b;
      m1    <= a_dual * mul_b;
      m2    <= a_real * b_dual;
      m3    <= PW'(b_real * b_real);
      sum_r <= sum_r_next;
      sum_d <= sum_d_next;
    end
  end

  // Stage 2.
  logic signed [WW-1:0] rr_next, rd_next;
  logic [PW:0]          diff, diff_neg;
  logic [PW-1:0]        m0_neg;

  always_comb begin
    rr_next  = '0;
    rd_next  = '0;
    m0_neg   = ~m0 + PW'(1);
    diff     = {m1[PW-1], m1} - {m2[PW-1], m2};
    diff_neg = ~diff + (PW + 1)'(1);
    case (op1)
      dnalu_pkg::OP_ADD, dnalu_pkg::OP_SUB, dnalu_pkg::OP_CONJ: begin
        rr_next = $signed({{(WW-33){sum_r[32]}}, sum_r});
        rd_next = $signed({{(WW-33){sum_d[32]}}, sum_d});
      end
      dnalu_pkg::OP_MUL: begin
        rr_next = $signed({{2{m0[PW-1]}}, m0}) >>> FB;
        rd_next = ($signed({{2{m2[PW-1]}}, m2}) + $signed({{2{m1[PW-1]}}, m1})) >>> FB;
      end
      dnalu_pkg::OP_SCALE: begin
        rr_next = $signed({{2{m0[PW-1]}}, m0}) >>> FB;
        rd_next = $signed({{2{m1[PW-1]}}, m1}) >>> FB;
      end
      default: begin
        rr_next = '0;
        rd_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (e2) begin
      op2    <= op1;
      bz2    <= bz1;
      rr_w   <= rr_next;
      rd_w   <= rd_next;
      den2   <= m3;
      neg_r2 <= m0[PW-1];
      mag_r2 <= m0[PW-1] ? m0_neg : m0;
      neg_d2 <= diff[PW];
      mag_d2 <= diff[PW] ? diff_neg[PW-1:0] : diff[PW-1:0];
    end
  end

  // Stage 3: final values for the short operations, divider setup for divide.
  logic [32:0] clip_r, clip_d;
  logic [NW-1:0] num_r, num_d;

  always_comb begin
    clip_r  = dnalu_pkg::clip_wide(rr_w);
    clip_d  = dnalu_pkg::clip_wide(rd_w);
    num_r   = {mag_r2, {FB{1'b0}}};
    num_d   = {mag_d2, {FB{1'b0}}};
    p0_next = '0;
    p0_next.den = den2;
    case (op2)
      dnalu_pkg::OP_ADD, dnalu_pkg::OP_SUB, dnalu_pkg::OP_CONJ,
      dnalu_pkg::OP_MUL, dnalu_pkg::OP_SCALE: begin
        p0_next.res_real = clip_r[31:0];
        p0_next.res_dual = clip_d[31:0];
        p0_next.sat      = clip_r[32] | clip_d[32];
      end
      dnalu_pkg::OP_DIV: begin
        if (bz2) begin
          p0_next.dbz = 1'b1;
        end else begin
          p0_next.is_div = 1'b1;
          p0_next.lr.neg = neg_r2;
          p0_next.lr.num = num_r;
          p0_next.lr.big = PW'(num_r[NW-1:QW]) >= den2;
          p0_next.lr.rem = PW'(num_r[NW-1:QW]);
          p0_next.ld.neg = neg_d2;
          p0_next.ld.num = num_d;
          p0_next.ld.big = PW'(num_d[NW-1:QW]) >= den2;
          p0_next.ld.rem = PW'(num_d[NW-1:QW]);
        end
      end
      default: begin
        p0_next.is_div = 1'b0;
      end
    endcase
  end

  // Divide steps: stage k brings down dividend bit QW-k.
  always_comb begin
    for (int k = 1; k <= NS; k++) begin
      pipe_step[k]    = pipe[k-1];
      pipe_step[k].lr = dnalu_pkg::lane_step(pipe[k-1].lr, pipe[k-1].den, QW - k);
      pipe_step[k].ld = dnalu_pkg::lane_step(pipe[k-1].ld, pipe[k-1].den, QW - k);
    end
  end

  always_ff @(posedge clk) begin
    if (ep[0]) begin
      pipe[0] <= p0_next;
    end
    for (int k = 1; k <= NS; k++) begin
      if (ep[k]) begin
        pipe[k] <= pipe_step[k];
      end
    end
  end

  // Output register.
  logic [32:0] fin_r, fin_d;

  always_comb begin
    fin_r = dnalu_pkg::lane_result(pipe[NS].lr);
    fin_d = dnalu_pkg::lane_result(pipe[NS].ld);
  end

  always_ff @(posedge clk) begin
    if (eo) begin
      if (pipe[NS].is_div) begin
        res_real  <= fin_r[31:0];
        res_dual  <= fin_d[31:0];
        saturated <= fin_r[32] | fin_d[32];
      end else begin
        res_real  <= pipe[NS].res_real;
        res_dual  <= pipe[NS].res_dual;
        saturated <= pipe[NS].sat;
      end
      divide_by_zero <= pipe[NS].dbz;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        vp[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      if (e1) begin
        v1 <= in_valid;
      end
      if (e2) begin
        v2 <= v1;
      end
      if (ep[0]) begin
        vp[0] <= v2;
      end
      for (int k = 1; k <= NS; k++) begin
        if (ep[k]) begin
          vp[k] <= vp[k-1];
        end
      end
      if (eo) begin
        out_valid <= vp[NS];
      end
    end
  end

`ifndef SYNTHESIS
  // Input is held off only when the whole pipeline is full behind a stalled beat.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output side is free");

  // A zero divisor gives a zero result and never a clip.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |->
      (res_real == 32'sd0 && res_dual == 32'sd0 && !saturated))
    else $error("divide by zero beat carries data");

  // After the first divide step a dual lane not flagged big keeps rem below den.
  assert property (@(posedge clk) disable iff (rst)
    (vp[1] && pipe[1].is_div && !pipe[1].ld.big) |-> (pipe[1].ld.rem < pipe[1].den))
    else $error("divider remainder out of range");

  // A beat in the last divide stage moves to the output when the output is free.
  assert property (@(posedge clk) disable iff (rst)
    (vp[NS] && eo) |=> out_valid)
    else $error("beat lost at the output register");
`endif

endmodule

// ===== dv/dual_number_alu_scoreboard.sv =====
`timescale 1ns / 1ps

module dual_number_alu_scoreboard (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_dual,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_dual,
  input  logic signed [31:0] factor,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] res_real,
  input  logic signed [31:0] res_dual,
  input  logic               saturated,
  input  logic               divide_by_zero,
  output int                 mismatches,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] rr;
    logic [31:0] rd;
    logic        sat;
    logic        dbz;
  } dual_res_t;

  dual_res_t results_due[$];

  // Clip an exact wide value to 32 bits, raising the saturation flag on a clip.
  function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end else if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic dual_res_t dual_alu_predict(input logic [2:0] op,
                                                 input logic signed [31:0] ar,
                                                 input logic signed [31:0] ad,
                                                 input logic signed [31:0] br,
                                                 input logic signed [31:0] bd,
                                                 input logic signed [31:0] kf);
    logic signed [127:0] xr, xd, yr, yd, k, wr, wd, den;
    dual_res_t r;
    xr = ar; xd = ad; yr = br; yd = bd; k = kf;
    wr = 0; wd = 0;
    r = '0;
    case (op)
      dnalu_pkg::OP_ADD: begin
        wr = xr + yr; wd = xd + yd;
      end
      dnalu_pkg::OP_SUB: begin
        wr = xr - yr; wd = xd - yd;
      end
      dnalu_pkg::OP_CONJ: begin
        wr = xr; wd = -xd;
      end
      // Arithmetic shift of a signed value rounds toward minus infinity.
      dnalu_pkg::OP_MUL: begin
        wr = (xr * yr) >>> dnalu_pkg::FRAC_BITS;
        wd = (xr * yd + yr * xd) >>> dnalu_pkg::FRAC_BITS;
      end
      dnalu_pkg::OP_SCALE: begin
        wr = (xr * k) >>> dnalu_pkg::FRAC_BITS;
        wd = (xd * k) >>> dnalu_pkg::FRAC_BITS;
      end
      dnalu_pkg::OP_DIV: begin
        if (yr == 0) begin
          r.dbz = 1'b1;
        end else begin
          // Signed division truncates toward zero.
          den = yr * yr;
          wr = ((xr * yr) <<< dnalu_pkg::FRAC_BITS) / den;
          wd = ((xd * yr - xr * yd) <<< dnalu_pkg::FRAC_BITS) / den;
        end
      end
      default: ;
    endcase
    r.rr = clip32(wr, r.sat);
    r.rd = clip32(wd, r.sat);
    return r;
  endfunction

  assign pending = results_due.size();

  always @(posedge clk) begin
    dual_res_t want;
    if (rst) begin
      mismatches <= 0;
    end else begin
      if (in_valid && in_ready) begin
        results_due.push_back(dual_alu_predict(opcode, a_real, a_dual, b_real, b_dual,
                                               factor));
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("ERROR: result beat with nothing expected: %h %h sat=%b dbz=%b",
                     res_real, res_dual, saturated, divide_by_zero);
          end
        end else begin
          want = results_due.pop_front();
          if (want.rr !== res_real || want.rd !== res_dual || want.sat !== saturated ||
              want.dbz !== divide_by_zero) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("ERROR: expected real=%h dual=%h sat=%b dbz=%b, got %h %h %b %b",
                       want.rr, want.rd, want.sat, want.dbz,
                       res_real, res_dual, saturated, divide_by_zero);
            end
          end
        end
      end
    end
  end

endmodule

// ===== dv/dual_number_alu_core_tb.sv =====
`timescale 1ns / 1ps

module dual_number_alu_core_tb;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 1730;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] opcode = '0;
  logic signed [31:0] a_real = '0, a_dual = '0, b_real = '0, b_dual = '0, factor = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] res_real, res_dual;
  logic saturated, divide_by_zero;
  int mismatches, pending;
  int idle_in = 0, idle_out = 0;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dual_number_alu_core DUT (.*);

  dual_number_alu_scoreboard u_scoreboard (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_out);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dual_number_alu_core_tb: done, errors");
      $finish;
    end
  end

  // Drive one beat; valid is only lowered during an idle gap.
  task automatic send_beat(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ad,
                           input logic [31:0] br, input logic [31:0] bd,
                           input logic [31:0] k);
    if ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_in);
    end
    in_valid <= 1'b1;
    opcode <= op; a_real <= ar; a_dual <= ad; b_real <= br; b_dual <= bd; factor <= k;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'($signed($urandom_range(8 << 16))) - (4 << 16);
      4: return 32'($urandom_range(255)) - 128;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(dnalu_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              '0);
    send_beat(dnalu_pkg::OP_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0000_4000,
              '0);
    send_beat(dnalu_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff,
              '0);
    send_beat(dnalu_pkg::OP_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000,
              '0);
    send_beat(dnalu_pkg::OP_CONJ, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
              '1);
    send_beat(dnalu_pkg::OP_CONJ, 32'hfffe_0000, 32'h0001_2345, '0, '0, '0);
    send_beat(dnalu_pkg::OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'hffff_0000,
              '0);
    send_beat(dnalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              '0);
    send_beat(dnalu_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff,
              '0);
    send_beat(dnalu_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              '1);
    send_beat(dnalu_pkg::OP_SCALE, 32'h0001_8000, 32'hffff_8000, '0, '0, 32'hfffe_0000);
    send_beat(dnalu_pkg::OP_SCALE, 32'h8000_0000, 32'h7fff_ffff, '0, '0, 32'h8000_0000);
    send_beat(dnalu_pkg::OP_SCALE, 32'hffff_ffff, 32'h0000_0001, '0, '0, 32'h0000_0001);
    send_beat(dnalu_pkg::OP_DIV, 32'h0006_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
              '0);
    send_beat(dnalu_pkg::OP_DIV, 32'h0001_0000, 32'h0002_0000, '0, 32'h0001_0000, '1);
    send_beat(dnalu_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff,
              '0);
    send_beat(dnalu_pkg::OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000,
              '0);
    send_beat(dnalu_pkg::OP_DIV, 32'hffff_0000, 32'h0000_0003, 32'h0003_0000, 32'hffff_ffff,
              '0);
    send_beat(dnalu_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              '0);
    send_beat(OP_RSVD6, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1);
    send_beat(OP_RSVD7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 0) begin
        idle_in = 32; idle_out = 71;
      end else if (i == RANDOM_ITEMS / 3) begin
        idle_in = 71; idle_out = 32;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        idle_in = 0; idle_out = 0;
      end
      // Mostly legal opcodes; the two unused codes show up now and then.
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      send_beat(op, pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("dual_number_alu_core_tb: done, clean");
    end else begin
      $display("dual_number_alu_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== dual_number_alu_core.f =====
design/dnalu_pkg.sv
design/dual_number_alu_core.sv
dv/dual_number_alu_scoreboard.sv
dv/dual_number_alu_core_tb.sv
